>>> sv/prmf_pkg.sv
// prmf_pkg: shared constants and types for the push-relabel max-flow unit.
// Used by prmf_cap_mem, prmf_flow_mem and push_relabel_max_flow_unit.
package prmf_pkg;

    localparam int N_VTX  = 16;
    localparam int VTX_W  = 4;
    localparam int CNT_W  = 5;
    localparam int ADDR_W = 8;
    localparam int CAP_W  = 16;
    localparam int FLOW_W = 17;
    localparam int RES_W  = 18;
    localparam int EXC_W  = 30;
    localparam int HGT_W  = 6;
    localparam int OUT_W  = 20;
    localparam int ACC_W  = 22;

    localparam logic [EXC_W-1:0] SOURCE_EXCESS = 30'd1000000000;
    localparam logic [CNT_W-1:0] VC_RESET      = 5'd16;
    localparam logic [CNT_W-1:0] VC_MIN        = 5'd2;
    localparam logic [CNT_W-1:0] VC_MAX        = 5'd16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef struct packed {
        logic                     en;
        logic [ADDR_W-1:0]        addr;
        logic signed [FLOW_W-1:0] data;
    } flow_wr_t;

endpackage

>>> sv/prmf_cap_mem.sv
// prmf_cap_mem: capacity store, one write and one registered read port.
// Entries read as zero until written. Depends on prmf_pkg.
module prmf_cap_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [prmf_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [prmf_pkg::CAP_W-1:0]    wr_data,
    input  logic [prmf_pkg::ADDR_W-1:0]   rd_addr,
    output logic [prmf_pkg::CAP_W-1:0]    rd_data
);

    logic [prmf_pkg::CAP_W-1:0] mem [1 << prmf_pkg::ADDR_W];
    logic [(1 << prmf_pkg::ADDR_W)-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

endmodule

>>> sv/prmf_flow_mem.sv
// prmf_flow_mem: flow store, one write port and two registered read ports.
// A clear pulse zeroes every entry at once. Depends on prmf_pkg.
module prmf_flow_mem (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clr,
    input  prmf_pkg::flow_wr_t                wr,
    input  logic [prmf_pkg::ADDR_W-1:0]       rd_a_addr,
    input  logic [prmf_pkg::ADDR_W-1:0]       rd_b_addr,
    output logic signed [prmf_pkg::FLOW_W-1:0] rd_a_data,
    output logic signed [prmf_pkg::FLOW_W-1:0] rd_b_data
);

    logic signed [prmf_pkg::FLOW_W-1:0] mem [1 << prmf_pkg::ADDR_W];
    logic [(1 << prmf_pkg::ADDR_W)-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clr)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_a_data <= valid_reg[rd_a_addr] ? mem[rd_a_addr] : '0;
        rd_b_data <= valid_reg[rd_b_addr] ? mem[rd_b_addr] : '0;
    end

endmodule

>>> sv/push_relabel_max_flow_unit.sv
// push_relabel_max_flow_unit: FIFO push-relabel max flow over a 16x16 matrix.
// Depends on prmf_pkg, prmf_cap_mem and prmf_flow_mem.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid / in_stall     | operation, from_vertex, to_vertex,
//          |                         | capacity_value, source, sink
//  out     | out_valid / out_stall   | total_flow
//  config  | config_write            | config_data (vertex_count)
//
// A load word is written to the capacity store as it is taken. A run saturates
// each source edge, then pops the queue, discharging and relabelling each vertex,
// and sums the flow into the sink; every step waits on the registered memory read.
// Reset clears the capacity store (valid bits) and sets vertex_count to 16.
// in_stall is high while a run is in progress; a finished result waits in the
// output register while out_stall is high, and loads are still taken then.
module push_relabel_max_flow_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          config_write,
    input  logic [prmf_pkg::CNT_W-1:0]    config_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [prmf_pkg::VTX_W-1:0]    from_vertex,
    input  logic [prmf_pkg::VTX_W-1:0]    to_vertex,
    input  logic [prmf_pkg::CAP_W-1:0]    capacity_value,
    input  logic [prmf_pkg::VTX_W-1:0]    source,
    input  logic [prmf_pkg::VTX_W-1:0]    sink,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [prmf_pkg::OUT_W-1:0]    total_flow
);

    typedef enum logic [3:0] {
        S_IDLE, S_SAT, S_EVAL, S_PUSH2, S_POP, S_DIS,
        S_LIFT, S_LIFT_EV, S_SUM, S_SUM_EV, S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [prmf_pkg::CNT_W-1:0]  vc_reg, n_reg, n_next, i_reg, i_next;
    logic [prmf_pkg::VTX_W-1:0]  src_reg, src_next, snk_reg, snk_next;
    logic [prmf_pkg::VTX_W-1:0]  u_reg, u_next, v_reg, v_next;
    logic [prmf_pkg::VTX_W-1:0]  qhead_reg, qhead_next;
    logic [prmf_pkg::CNT_W-1:0]  qcount_reg, qcount_next;
    logic                        sat_reg, sat_next, found_reg, found_next;
    logic [prmf_pkg::HGT_W-1:0]  best_reg, best_next;
    logic signed [prmf_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [prmf_pkg::FLOW_W-1:0] d_reg, d_next;
    logic signed [prmf_pkg::FLOW_W-1:0] fb_reg, fb_next;
    logic [prmf_pkg::OUT_W-1:0]  res_reg, res_next, total_flow_reg;
    logic                        out_valid_reg;

    logic [prmf_pkg::EXC_W-1:0]  excess_reg [prmf_pkg::N_VTX];
    logic [prmf_pkg::HGT_W-1:0]  height_reg [prmf_pkg::N_VTX];
    logic [prmf_pkg::CNT_W-1:0]  arc_reg    [prmf_pkg::N_VTX];
    logic [prmf_pkg::VTX_W-1:0]  queue_reg  [prmf_pkg::N_VTX];

    logic [prmf_pkg::CAP_W-1:0]  cap_q;
    logic signed [prmf_pkg::FLOW_W-1:0] fa_q, fb_q;
    logic [prmf_pkg::ADDR_W-1:0] rd_a, rd_b;
    prmf_pkg::flow_wr_t          fwr;
    logic                        flow_clr;

    logic                        in_acc, load_we, run_go, run_bad;
    logic [prmf_pkg::CNT_W-1:0]  n_cur;
    logic [prmf_pkg::CAP_W-1:0]  cap_eff;
    logic signed [prmf_pkg::RES_W-1:0] resid;
    logic                        resid_pos, admissible, do_push, enq;
    logic [prmf_pkg::FLOW_W-1:0] r_mag, d_cur;
    logic [prmf_pkg::EXC_W-1:0]  ex_u, ex_v;
    logic signed [prmf_pkg::FLOW_W+1:0] fa_sum, fb_dif;
    logic                        lift_done, arc_inc, out_load;
    logic [prmf_pkg::VTX_W-1:0]  qtail, arc_u;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign load_we    = in_acc && (operation == prmf_pkg::OP_LOAD);
    assign run_go     = in_acc && (operation == prmf_pkg::OP_RUN);
    assign out_valid  = out_valid_reg;
    assign total_flow = total_flow_reg;

    assign n_cur   = (vc_reg < prmf_pkg::VC_MIN) ? prmf_pkg::VC_MIN :
                     (vc_reg > prmf_pkg::VC_MAX) ? prmf_pkg::VC_MAX : vc_reg;
    assign run_bad = (source == sink) || ({1'b0, source} >= n_cur) ||
                     ({1'b0, sink} >= n_cur);

    assign cap_eff   = (u_reg == v_reg) ? '0 : cap_q;
    assign resid     = $signed({2'b00, cap_eff}) - prmf_pkg::RES_W'(fa_q);
    assign resid_pos = !resid[prmf_pkg::RES_W-1] && (resid != '0);
    assign r_mag     = resid[prmf_pkg::RES_W-1] ? '0 : resid[prmf_pkg::FLOW_W-1:0];
    assign ex_u      = excess_reg[u_reg];
    assign ex_v      = excess_reg[v_reg];
    assign d_cur     = (ex_u < prmf_pkg::EXC_W'(r_mag)) ? ex_u[prmf_pkg::FLOW_W-1:0] : r_mag;
    assign admissible = resid_pos && (height_reg[u_reg] > height_reg[v_reg]);
    assign do_push   = (state_reg == S_EVAL) && (sat_reg || admissible);
    assign arc_inc   = (state_reg == S_EVAL) && !sat_reg && !admissible;
    assign qtail     = qhead_reg + qcount_reg[prmf_pkg::VTX_W-1:0];
    assign enq       = do_push && (d_cur != '0) && (ex_v == '0) &&
                       (qcount_reg < 5'(prmf_pkg::N_VTX));
    assign lift_done = (state_reg == S_LIFT) && (i_reg == n_reg);
    assign arc_u     = arc_reg[u_reg][prmf_pkg::VTX_W-1:0];
    assign fa_sum    = (prmf_pkg::FLOW_W+2)'(fa_q) + $signed({2'b00, d_cur});
    assign fb_dif    = (prmf_pkg::FLOW_W+2)'(fb_reg) - $signed({2'b00, d_reg});
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign flow_clr  = run_go;

    always_comb
    begin
        case (state_reg)
            S_SAT:   begin rd_a = {src_reg, i_reg[3:0]}; rd_b = {i_reg[3:0], src_reg}; end
            S_DIS:   begin rd_a = {u_reg, arc_u};        rd_b = {arc_u, u_reg};        end
            S_LIFT:  begin rd_a = {u_reg, i_reg[3:0]};   rd_b = {i_reg[3:0], u_reg};   end
            S_SUM:   begin rd_a = {i_reg[3:0], snk_reg}; rd_b = {snk_reg, i_reg[3:0]}; end
            default: begin rd_a = {u_reg, v_reg};        rd_b = {v_reg, u_reg};        end
        endcase
    end

    always_comb
    begin
        fwr.en   = 1'b0;
        fwr.addr = {u_reg, v_reg};
        fwr.data = fa_sum[prmf_pkg::FLOW_W-1:0];
        if (do_push)
        begin
            fwr.en = 1'b1;
        end
        else if (state_reg == S_PUSH2)
        begin
            fwr.en   = 1'b1;
            fwr.addr = {v_reg, u_reg};
            fwr.data = fb_dif[prmf_pkg::FLOW_W-1:0];
        end
    end

    prmf_cap_mem u_cap (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (load_we),
        .wr_addr ({from_vertex, to_vertex}),
        .wr_data (capacity_value),
        .rd_addr (rd_a),
        .rd_data (cap_q)
    );

    prmf_flow_mem u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (flow_clr),
        .wr        (fwr),
        .rd_a_addr (rd_a),
        .rd_b_addr (rd_b),
        .rd_a_data (fa_q),
        .rd_b_data (fb_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        src_next    = src_reg;
        snk_next    = snk_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        qhead_next  = qhead_reg;
        qcount_next = qcount_reg;
        sat_next    = sat_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        acc_next    = acc_reg;
        d_next      = d_reg;
        fb_next     = fb_reg;
        res_next    = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (run_go)
                begin
                    n_next      = n_cur;
                    src_next    = source;
                    snk_next    = sink;
                    qhead_next  = '0;
                    qcount_next = '0;
                    i_next      = '0;
                    res_next    = '0;
                    state_next  = run_bad ? S_DONE : S_SAT;
                end
            end
            S_SAT:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = S_POP;
                end
                else if (i_reg[3:0] == src_reg)
                begin
                    i_next = 5'(i_reg + 5'd1);
                end
                else
                begin
                    u_next     = src_reg;
                    v_next     = i_reg[3:0];
                    sat_next   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                d_next  = d_cur;
                fb_next = fb_q;
                if (do_push)
                begin
                    if (enq)
                    begin
                        qcount_next = 5'(qcount_reg + 5'd1);
                    end
                    state_next = S_PUSH2;
                end
                else
                begin
                    state_next = S_DIS;
                end
            end
            S_PUSH2:
            begin
                if (sat_reg)
                begin
                    i_next     = 5'(i_reg + 5'd1);
                    state_next = S_SAT;
                end
                else
                begin
                    state_next = S_DIS;
                end
            end
            S_POP:
            begin
                if (qcount_reg == '0)
                begin
                    i_next     = '0;
                    acc_next   = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    u_next      = queue_reg[qhead_reg];
                    qhead_next  = 4'(qhead_reg + 4'd1);
                    qcount_next = 5'(qcount_reg - 5'd1);
                    if (queue_reg[qhead_reg] != src_reg && queue_reg[qhead_reg] != snk_reg)
                    begin
                        state_next = S_DIS;
                    end
                end
            end
            S_DIS:
            begin
                sat_next = 1'b0;
                if (ex_u == '0)
                begin
                    state_next = S_POP;
                end
                else if (arc_reg[u_reg] < n_reg)
                begin
                    v_next     = arc_u;
                    state_next = S_EVAL;
                end
                else
                begin
                    i_next     = '0;
                    found_next = 1'b0;
                    state_next = S_LIFT;
                end
            end
            S_LIFT:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = S_DIS;
                end
                else
                begin
                    v_next     = i_reg[3:0];
                    state_next = S_LIFT_EV;
                end
            end
            S_LIFT_EV:
            begin
                if (resid_pos && (!found_reg || height_reg[v_reg] < best_reg))
                begin
                    best_next  = height_reg[v_reg];
                    found_next = 1'b1;
                end
                i_next     = 5'(i_reg + 5'd1);
                state_next = S_LIFT;
            end
            S_SUM:
            begin
                if (i_reg == n_reg)
                begin
                    res_next   = acc_reg[prmf_pkg::OUT_W-1:0];
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SUM_EV;
                end
            end
            S_SUM_EV:
            begin
                acc_next   = acc_reg + prmf_pkg::ACC_W'(fa_q);
                i_next     = 5'(i_reg + 5'd1);
                state_next = S_SUM;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vc_reg         <= prmf_pkg::VC_RESET;
            qhead_reg      <= '0;
            qcount_reg     <= '0;
            out_valid_reg  <= 1'b0;
            total_flow_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            qhead_reg  <= qhead_next;
            qcount_reg <= qcount_next;
            if (config_write)
            begin
                vc_reg <= config_data;
            end
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                total_flow_reg <= res_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        src_reg   <= src_next;
        snk_reg   <= snk_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        sat_reg   <= sat_next;
        found_reg <= found_next;
        best_reg  <= best_next;
        acc_reg   <= acc_next;
        d_reg     <= d_next;
        fb_reg    <= fb_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (run_go)
        begin
            for (int k = 0; k < prmf_pkg::N_VTX; k++)
            begin
                excess_reg[k] <= '0;
                height_reg[k] <= '0;
                arc_reg[k]    <= '0;
            end
            excess_reg[source] <= prmf_pkg::SOURCE_EXCESS;
            height_reg[source] <= prmf_pkg::HGT_W'(n_cur);
        end
        else
        begin
            if (do_push)
            begin
                excess_reg[u_reg] <= ex_u - prmf_pkg::EXC_W'(d_cur);
                excess_reg[v_reg] <= ex_v + prmf_pkg::EXC_W'(d_cur);
            end
            if (enq)
            begin
                queue_reg[qtail] <= v_reg;
            end
            if (arc_inc)
            begin
                arc_reg[u_reg] <= 5'(arc_reg[u_reg] + 5'd1);
            end
            if (lift_done)
            begin
                arc_reg[u_reg] <= '0;
                if (found_reg)
                begin
                    height_reg[u_reg] <= 6'(best_reg + 6'd1);
                end
            end
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcount_reg <= 5'(prmf_pkg::N_VTX))
        else $error("active queue count exceeds vertex count");

    a_push_moves_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && !sat_reg && admissible) |-> (d_cur != '0))
        else $error("admissible push moved no flow");

    a_same_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        (run_go && source == sink) |=> (state_reg == S_DONE && res_reg == '0))
        else $error("run with source equal to sink did not report zero");

endmodule
